// File: rtl/jsld_pkg.sv
// Shared types and codes for the JSON string literal decoder.
`default_nettype none

package jsld_pkg;

   localparam int unsigned LimitWidth = 19;
   localparam logic [LimitWidth-1:0] LIMIT_RESET = 19'h40000;
   localparam int unsigned QueueDepth = 4;

   // result status codes
   localparam logic [3:0] ST_DATA      = 4'd0;
   localparam logic [3:0] ST_DONE      = 4'd1;
   localparam logic [3:0] ST_NO_OPEN   = 4'd2;
   localparam logic [3:0] ST_CONTROL   = 4'd3;
   localparam logic [3:0] ST_BAD_UTF8  = 4'd4;
   localparam logic [3:0] ST_BAD_ESC   = 4'd5;
   localparam logic [3:0] ST_BAD_HEX   = 4'd6;
   localparam logic [3:0] ST_PAIR_INC  = 4'd7;
   localparam logic [3:0] ST_PAIR_INV  = 4'd8;
   localparam logic [3:0] ST_LONE_LOW  = 4'd9;
   localparam logic [3:0] ST_LIMIT     = 4'd10;
   localparam logic [3:0] ST_NO_CLOSE  = 4'd11;
   localparam logic [3:0] ST_ESC_CUT   = 4'd12;

   // one queued unit of results: up to four bytes, or a single status result
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      last_idx;
      logic [3:0]      status;
   } jsld_job_type;

endpackage

`default_nettype wire

// File: rtl/jsld_front.sv
// Front end: accepts text bytes, runs the literal parser and emits result units.
`default_nettype none

module jsld_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [jsld_pkg::LimitWidth-1:0] csr_wdata,
   input  wire logic                          in_valid,
   input  wire logic [7:0]                    in_byte,
   input  wire logic                          in_end,
   output logic                               in_ready,
   input  wire logic                          q_full,
   output logic                               job_push,
   output jsld_pkg::jsld_job_type             job
);
   import jsld_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE, PH_STR, PH_UTF, PH_ESC, PH_HEX, PH_PAIR_BS, PH_PAIR_U, PH_HEX_LOW
   } phase_type;

   typedef struct packed {
      logic [3:0][7:0] data;
      logic [2:0]      n;
   } unit_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      d = 5'd16;
      if (c >= 8'h30 && c <= 8'h39) d = 5'(c - 8'h30);
      else if (c >= 8'h61 && c <= 8'h66) d = 5'(c - 8'h61 + 8'd10);
      else if (c >= 8'h41 && c <= 8'h46) d = 5'(c - 8'h41 + 8'd10);
      return d;
   endfunction

   function automatic unit_type encode(input logic [20:0] s);
      unit_type u;
      u = '0;
      if (s <= 21'h7F) begin
         u.data[0] = s[7:0];
         u.n = 3'd1;
      end else if (s <= 21'h7FF) begin
         u.data[0] = {3'b110, s[10:6]};
         u.data[1] = {2'b10, s[5:0]};
         u.n = 3'd2;
      end else if (s <= 21'hFFFF) begin
         u.data[0] = {4'b1110, s[15:12]};
         u.data[1] = {2'b10, s[11:6]};
         u.data[2] = {2'b10, s[5:0]};
         u.n = 3'd3;
      end else begin
         u.data[0] = {5'b11110, s[20:18]};
         u.data[1] = {2'b10, s[17:12]};
         u.data[2] = {2'b10, s[11:6]};
         u.data[3] = {2'b10, s[5:0]};
         u.n = 3'd4;
      end
      return u;
   endfunction

   phase_type               phase_ff, phase_in;
   logic [15:0]             hex_ff, hex_in;
   logic [2:0]              hseen_ff, hseen_in;
   logic [9:0]              high_ff, high_in;
   logic [3:0][7:0]         held_ff, held_in;
   logic [2:0]              len_ff, len_in;
   logic [2:0]              seen_ff, seen_in;
   logic [20:0]             scalar_ff, scalar_in;
   logic [LimitWidth-1:0]   bout_ff, bout_in;
   logic [LimitWidth-1:0]   limit_ff;

   logic                    accept;
   logic [4:0]              digit;
   logic [15:0]             hex_next;
   logic [20:0]             scalar_next;
   logic [20:0]             scalar_min;
   logic [2:0]              seen_next;
   logic                    commit_req;
   unit_type                commit_unit;
   logic                    status_req;
   logic [3:0]              status_code;
   logic [LimitWidth:0]     sum;

   assign in_ready = ~q_full;
   assign accept   = in_valid & ~q_full;

   assign digit       = hex_digit(in_byte);
   assign hex_next    = {hex_ff[11:0], digit[3:0]};
   assign scalar_next = {scalar_ff[14:0], in_byte[5:0]};
   assign seen_next   = seen_ff + 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      hex_in      = hex_ff;
      hseen_in    = hseen_ff;
      high_in     = high_ff;
      held_in     = held_ff;
      len_in      = len_ff;
      seen_in     = seen_ff;
      scalar_in   = scalar_ff;
      bout_in     = bout_ff;
      commit_req  = 1'b0;
      commit_unit = '0;
      status_req  = 1'b0;
      status_code = ST_DONE;
      scalar_min  = 21'h10000;
      sum         = '0;
      job_push    = 1'b0;
      job         = '0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (!in_end) begin
               if (in_byte == 8'h22) begin
                  phase_in = PH_STR;
                  bout_in  = '0;
               end else begin
                  status_req  = 1'b1;
                  status_code = ST_NO_OPEN;
               end
            end
         end
         PH_STR: begin
            priority if (in_end) begin
               status_req  = 1'b1;
               status_code = ST_NO_CLOSE;
            end else if (in_byte == 8'h22) begin
               status_req  = 1'b1;
               status_code = ST_DONE;
            end else if (in_byte == 8'h5C) begin
               phase_in = PH_ESC;
            end else if (in_byte < 8'h20) begin
               status_req  = 1'b1;
               status_code = ST_CONTROL;
            end else if (in_byte < 8'h80) begin
               commit_req          = 1'b1;
               commit_unit.data[0] = in_byte;
               commit_unit.n       = 3'd1;
            end else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) begin
               len_in     = 3'd2;
               scalar_in  = {16'd0, in_byte[4:0]};
               held_in[0] = in_byte;
               seen_in    = 3'd1;
               phase_in   = PH_UTF;
            end else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) begin
               len_in     = 3'd3;
               scalar_in  = {17'd0, in_byte[3:0]};
               held_in[0] = in_byte;
               seen_in    = 3'd1;
               phase_in   = PH_UTF;
            end else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) begin
               len_in     = 3'd4;
               scalar_in  = {18'd0, in_byte[2:0]};
               held_in[0] = in_byte;
               seen_in    = 3'd1;
               phase_in   = PH_UTF;
            end else begin
               status_req  = 1'b1;
               status_code = ST_BAD_UTF8;
            end
         end
         PH_UTF: begin
            if (in_end || in_byte[7:6] != 2'b10) begin
               status_req  = 1'b1;
               status_code = ST_BAD_UTF8;
            end else begin
               held_in[seen_ff[1:0]] = in_byte;
               scalar_in = scalar_next;
               seen_in   = seen_next;
               if (len_ff == 3'd2) scalar_min = 21'h80;
               else if (len_ff == 3'd3) scalar_min = 21'h800;
               if (seen_next >= len_ff) begin
                  if (scalar_next < scalar_min || scalar_next > 21'h10FFFF ||
                      (scalar_next >= 21'hD800 && scalar_next <= 21'hDFFF)) begin
                     status_req  = 1'b1;
                     status_code = ST_BAD_UTF8;
                  end else begin
                     commit_req       = 1'b1;
                     commit_unit.data = held_in;
                     commit_unit.n    = len_ff;
                  end
               end
            end
         end
         PH_ESC: begin
            if (in_end) begin
               status_req  = 1'b1;
               status_code = ST_ESC_CUT;
            end else begin
               commit_unit.n = 3'd1;
               unique case (in_byte)
                  8'h22, 8'h5C, 8'h2F: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = in_byte;
                  end
                  8'h62: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = 8'h08;
                  end
                  8'h66: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = 8'h0C;
                  end
                  8'h6E: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = 8'h0A;
                  end
                  8'h72: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = 8'h0D;
                  end
                  8'h74: begin
                     commit_req          = 1'b1;
                     commit_unit.data[0] = 8'h09;
                  end
                  8'h75: begin
                     hex_in   = '0;
                     hseen_in = '0;
                     phase_in = PH_HEX;
                  end
                  default: begin
                     status_req  = 1'b1;
                     status_code = ST_BAD_ESC;
                  end
               endcase
            end
         end
         PH_HEX: begin
            if (in_end || digit[4]) begin
               status_req  = 1'b1;
               status_code = ST_BAD_HEX;
            end else begin
               hex_in   = hex_next;
               hseen_in = hseen_ff + 3'd1;
               if (hseen_ff == 3'd3) begin
                  priority if (hex_next >= 16'hD800 && hex_next <= 16'hDBFF) begin
                     high_in  = hex_next[9:0];
                     phase_in = PH_PAIR_BS;
                  end else if (hex_next >= 16'hDC00) begin
                     if (hex_next <= 16'hDFFF) begin
                        status_req  = 1'b1;
                        status_code = ST_LONE_LOW;
                     end else begin
                        commit_req  = 1'b1;
                        commit_unit = encode({5'd0, hex_next});
                     end
                  end else begin
                     commit_req  = 1'b1;
                     commit_unit = encode({5'd0, hex_next});
                  end
               end
            end
         end
         PH_PAIR_BS: begin
            if (in_end || in_byte != 8'h5C) begin
               status_req  = 1'b1;
               status_code = ST_PAIR_INC;
            end else begin
               phase_in = PH_PAIR_U;
            end
         end
         PH_PAIR_U: begin
            if (in_end || in_byte != 8'h75) begin
               status_req  = 1'b1;
               status_code = ST_PAIR_INC;
            end else begin
               hex_in   = '0;
               hseen_in = '0;
               phase_in = PH_HEX_LOW;
            end
         end
         PH_HEX_LOW: begin
            priority if (in_end) begin
               status_req  = 1'b1;
               status_code = ST_PAIR_INC;
            end else if (digit[4]) begin
               status_req  = 1'b1;
               status_code = ST_PAIR_INV;
            end else begin
               hex_in   = hex_next;
               hseen_in = hseen_ff + 3'd1;
               if (hseen_ff == 3'd3) begin
                  if (hex_next < 16'hDC00 || hex_next > 16'hDFFF) begin
                     status_req  = 1'b1;
                     status_code = ST_PAIR_INV;
                  end else begin
                     // 0x10000 plus the high half lands as high_ff + 64 above bit 10
                     commit_req  = 1'b1;
                     commit_unit = encode({{1'b0, high_ff} + 11'd64, hex_next[9:0]});
                  end
               end
            end
         end
      endcase

      // a decoded unit goes out whole or not at all
      if (commit_req) begin
         sum = {1'b0, bout_ff} + (LimitWidth + 1)'(commit_unit.n);
         if (sum > {1'b0, limit_ff}) begin
            status_req  = 1'b1;
            status_code = ST_LIMIT;
         end else begin
            bout_in      = sum[LimitWidth-1:0];
            phase_in     = PH_STR;
            job_push     = accept;
            job.data     = commit_unit.data;
            job.last_idx = 2'(commit_unit.n - 3'd1);
            job.status   = ST_DATA;
         end
      end

      // every status result ends the literal
      if (status_req) begin
         phase_in   = PH_IDLE;
         job_push   = accept;
         job        = '0;
         job.status = status_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         hex_ff    <= '0;
         hseen_ff  <= '0;
         high_ff   <= '0;
         len_ff    <= '0;
         seen_ff   <= '0;
         scalar_ff <= '0;
         bout_ff   <= '0;
         limit_ff  <= LIMIT_RESET;
      end else begin
         if (accept) begin
            phase_ff  <= phase_in;
            hex_ff    <= hex_in;
            hseen_ff  <= hseen_in;
            high_ff   <= high_in;
            len_ff    <= len_in;
            seen_ff   <= seen_in;
            scalar_ff <= scalar_in;
            bout_ff   <= bout_in;
         end
         if (csr_we) limit_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) held_ff <= held_in;
   end

endmodule

`default_nettype wire

// File: rtl/jsld_queue.sv
// Short queue of result units between the parser and the output sequencer.
`default_nettype none

module jsld_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire jsld_pkg::jsld_job_type push_job,
   input  wire logic                   pop,
   output logic                        full,
   output logic                        empty,
   output jsld_pkg::jsld_job_type      head
);
   import jsld_pkg::*;

   localparam int unsigned PtrWidth = $clog2(QueueDepth);

   jsld_job_type                  mem_ff [QueueDepth];
   logic [PtrWidth-1:0]           wptr_ff, wptr_in;
   logic [PtrWidth-1:0]           rptr_ff, rptr_in;
   logic [PtrWidth:0]             count_ff, count_in;

   assign full  = (count_ff == (PtrWidth + 1)'(QueueDepth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + PtrWidth'(1) : wptr_ff;
      rptr_in  = pop ? rptr_ff + PtrWidth'(1) : rptr_ff;
      count_in = count_ff + (PtrWidth + 1)'(push) - (PtrWidth + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wptr_ff] <= push_job;
   end

endmodule

`default_nettype wire

// File: rtl/jsld_back.sv
// Output sequencer: walks the bytes of the head unit, one result transfer a cycle while out_ready is high.
`default_nettype none

module jsld_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   q_empty,
   input  wire jsld_pkg::jsld_job_type head,
   output logic                        q_pop,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output logic [7:0]                  out_byte,
   output logic [3:0]                  out_status,
   output logic                        out_last
);
   import jsld_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       xfer;

   assign out_valid  = ~q_empty;
   assign out_byte   = head.data[idx_ff];
   assign out_status = head.status;
   assign out_last   = (idx_ff == head.last_idx);
   assign xfer       = out_valid & out_ready;
   assign q_pop      = xfer & out_last;

   always_comb begin
      idx_in = idx_ff;
      if (xfer) idx_in = out_last ? 2'd0 : idx_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/json_string_literal_decoder_core.sv
// A result is registered in the unit queue before it appears on the result port.
// Throughput: one text byte per cycle while the unit queue is not full; a decoded unit
// of n bytes takes n result transfers, and a four-entry unit queue absorbs the difference.
// Reset: synchronous, active high; parser idle awaiting a quote, queue empty,
// byte limit back to 262144.
`default_nettype none

module json_string_literal_decoder_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [jsld_pkg::LimitWidth-1:0] csr_wdata,   // byte_limit
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   input  wire logic [7:0]                      req_tdata,   // [7:0] in_byte
   input  wire logic                            req_tuser,   // [0] text_end
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   output logic [7:0]                           rsp_tdata,   // [7:0] out_byte
   output logic [3:0]                           rsp_tuser,   // [3:0] status
   output logic                                 rsp_tlast
);
   import jsld_pkg::*;

   jsld_job_type job;
   jsld_job_type head;
   logic         job_push;
   logic         q_full;
   logic         q_empty;
   logic         q_pop;

   jsld_front u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .in_valid  (req_tvalid),
      .in_byte   (req_tdata),
      .in_end    (req_tuser),
      .in_ready  (req_tready),
      .q_full    (q_full),
      .job_push  (job_push),
      .job       (job)
   );

   jsld_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_job (job),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   jsld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .head       (head),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire
